// ===== design/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console cursor engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

   localparam int MaxColumnsDefault = 128;
   localparam int MaxRowsDefault    = 32;
   localparam int QueueDepth        = 2;

   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChTilde = 8'h7E;
   localparam logic [7:0] ChBel   = 8'h07;
   localparam logic [7:0] ChBs    = 8'h08;
   localparam logic [7:0] ChLf    = 8'h0A;
   localparam logic [7:0] ChCr    = 8'h0D;

   localparam logic [7:0]  ColumnCountReset = 8'd80;
   localparam logic [5:0]  RowCountReset    = 6'd25;
   localparam logic [31:0] DirtyReset       = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      KindPut   = 2'd0,
      KindClear = 2'd1,
      KindRead  = 2'd2,
      KindNone  = 2'd3
   } kind_type;

   typedef enum logic {
      CsrColumnCount = 1'b0,
      CsrRowCount    = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      OpPrint,
      OpBell,
      OpBackspace,
      OpNewRow,
      OpOther,
      OpClear,
      OpRead,
      OpNop
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] char_code;
      logic       end_of_string;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef struct packed {
      logic pop;
      logic initialising;
   } back_status_type;

endpackage

`default_nettype wire

// ===== design/tcce_ram.sv =====
// ----------------------------------------------------------------------------
// tcce_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
      read_data <= mem[read_addr];
   end

endmodule

`default_nettype wire

// ===== design/tcce_front.sv =====
// ----------------------------------------------------------------------------
// tcce_front
// Takes command words, sorts put-character words by byte class and holds
// them in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [1:0]                kind,
   input  wire logic [7:0]                char_code,
   input  wire logic                      end_of_string,
   input  wire logic [4:0]                read_row,
   input  wire logic [6:0]                read_col,
   input  wire tcce_pkg::back_status_type status,
   output tcce_pkg::queue_head_type       head
);

   localparam int PtrW = $clog2(tcce_pkg::QueueDepth);
   localparam int CntW = $clog2(tcce_pkg::QueueDepth + 1);
   localparam logic [PtrW-1:0] LastSlot = PtrW'(tcce_pkg::QueueDepth - 1);
   localparam logic [CntW-1:0] FullCount = CntW'(tcce_pkg::QueueDepth);

   tcce_pkg::item_type slot_ff [tcce_pkg::QueueDepth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;
   tcce_pkg::op_type   op;
   tcce_pkg::item_type item;
   logic               accept;

   always_comb begin
      unique case (tcce_pkg::kind_type'(kind))
         tcce_pkg::KindPut: begin
            priority if (char_code >= tcce_pkg::ChSpace && char_code <= tcce_pkg::ChTilde) begin
               op = tcce_pkg::OpPrint;
            end else if (char_code == tcce_pkg::ChBel) begin
               op = tcce_pkg::OpBell;
            end else if (char_code == tcce_pkg::ChBs) begin
               op = tcce_pkg::OpBackspace;
            end else if (char_code == tcce_pkg::ChLf || char_code == tcce_pkg::ChCr) begin
               op = tcce_pkg::OpNewRow;
            end else begin
               op = tcce_pkg::OpOther;
            end
         end
         tcce_pkg::KindClear: op = tcce_pkg::OpClear;
         tcce_pkg::KindRead:  op = tcce_pkg::OpRead;
         tcce_pkg::KindNone:  op = tcce_pkg::OpNop;
         default:             op = tcce_pkg::OpNop;
      endcase
   end

   assign item.op            = op;
   assign item.char_code     = char_code;
   assign item.end_of_string = end_of_string;
   assign item.read_row      = read_row;
   assign item.read_col      = read_col;

   assign busy   = (count_ff == FullCount) || status.initialising;
   assign accept = start && !busy;

   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (status.pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (accept && !status.pop) begin
         count_in = count_ff + 1'b1;
      end else if (!accept && status.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

`default_nettype wire

// ===== design/tcce_back.sv =====
// ----------------------------------------------------------------------------
// tcce_back
// Carries out queued words: cursor moves, text store writes and reads,
// scrolling, blanking sweeps and the dirty-row mask.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_back #(
   parameter int MAX_COLUMNS = tcce_pkg::MaxColumnsDefault,
   parameter int MAX_ROWS    = tcce_pkg::MaxRowsDefault
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [$clog2(MAX_COLUMNS):0]        cols,
   input  wire logic [$clog2(MAX_ROWS):0]           rows,
   input  wire tcce_pkg::queue_head_type            head,
   output tcce_pkg::back_status_type                status,
   output logic                                     rsp_valid,
   output logic [4:0]                               rsp_cursor_row,
   output logic [6:0]                               rsp_cursor_col,
   output logic [7:0]                               rsp_cell_char,
   output logic                                     rsp_bell,
   output logic                                     rsp_scrolled,
   output logic [31:0]                              rsp_dirty_rows
);

   localparam int CW    = $clog2(MAX_COLUMNS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int AW    = RW + CW;
   localparam int Depth = MAX_ROWS * (2 ** CW);
   localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);
   localparam logic [CW-1:0] LastCol  = CW'(MAX_COLUMNS - 1);

   typedef enum logic [1:0] {
      S_SWEEP,
      S_IDLE,
      S_EXEC,
      S_READ
   } state_type;

   state_type          state_ff, state_in;
   logic [RW-1:0]      top_ff, top_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [31:0]        dirty_ff, dirty_in;
   logic               init_ff, init_in;
   logic [AW-1:0]      sweep_addr_ff, sweep_addr_in;
   logic [AW-1:0]      sweep_last_ff, sweep_last_in;
   tcce_pkg::item_type item_ff, item_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [4:0]         rsp_row_ff, rsp_row_in;
   logic [6:0]         rsp_col_ff, rsp_col_in;
   logic [7:0]         rsp_char_ff, rsp_char_in;
   logic               rsp_bell_ff, rsp_bell_in;
   logic               rsp_scrolled_ff, rsp_scrolled_in;
   logic [31:0]        rsp_dirty_ff, rsp_dirty_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [7:0]         ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [7:0]         ram_rdata;

   logic [CW:0]        col_inc;
   logic [RW:0]        row_inc;
   logic               col_wrap;
   logic               row_over;
   logic [RW-1:0]      top_inc;
   logic [RW-1:0]      bs_row;
   logic [CW-1:0]      bs_col;
   logic [RW-1:0]      addr_row;
   logic [CW-1:0]      addr_col;
   logic [RW:0]        phys_sum;
   logic [RW-1:0]      phys_row;
   logic [AW-1:0]      cell_addr;
   logic               read_ok;
   logic [31:0]        rows_mask;
   logic [31:0]        cur_bit;
   logic [RW-1:0]      next_row;
   logic [CW-1:0]      next_col;
   logic [31:0]        next_dirty;
   logic               bell;
   logic               scroll;

   tcce_ram #(
      .WIDTH(8),
      .DEPTH(Depth)
   ) u_store (
      .clock       (clock),
      .write_enable(ram_we),
      .write_addr  (ram_waddr),
      .write_data  (ram_wdata),
      .read_addr   (ram_raddr),
      .read_data   (ram_rdata)
   );

   assign col_inc   = {1'b0, col_ff} + 1'b1;
   assign row_inc   = {1'b0, row_ff} + 1'b1;
   assign col_wrap  = col_inc >= cols;
   assign row_over  = row_inc >= rows;
   assign top_inc   = (({1'b0, top_ff} + 1'b1) == rows) ? '0 : top_ff + 1'b1;
   assign rows_mask = ~(32'hFFFF_FFFF << rows);
   assign cur_bit   = 32'd1 << row_ff;
   assign read_ok   = (6'(item_ff.read_row) < 6'(rows)) && (9'(item_ff.read_col) < 9'(cols));

   always_comb begin
      bs_row = row_ff;
      bs_col = col_ff;
      if (col_ff != '0) begin
         bs_col = col_ff - 1'b1;
      end else if (row_ff != '0) begin
         bs_row = row_ff - 1'b1;
      end
   end

   always_comb begin
      unique case (item_ff.op)
         tcce_pkg::OpBackspace: begin
            addr_row = bs_row;
            addr_col = bs_col;
         end
         tcce_pkg::OpRead: begin
            addr_row = RW'(item_ff.read_row);
            addr_col = CW'(item_ff.read_col);
         end
         default: begin
            addr_row = row_ff;
            addr_col = col_ff;
         end
      endcase
   end

   assign phys_sum  = {1'b0, top_ff} + {1'b0, addr_row};
   assign phys_row  = (phys_sum >= rows) ? RW'(phys_sum - rows) : RW'(phys_sum);
   assign cell_addr = {phys_row, addr_col};

   // Effect of the word held in EXEC
   always_comb begin
      next_row   = row_ff;
      next_col   = col_ff;
      next_dirty = dirty_ff;
      bell       = 1'b0;
      scroll     = 1'b0;
      unique case (item_ff.op)
         tcce_pkg::OpPrint: begin
            next_dirty = dirty_ff | cur_bit;
            if (col_wrap) begin
               next_col = '0;
               if (row_over) begin
                  scroll = 1'b1;
               end else begin
                  next_row = RW'(row_inc);
               end
            end else begin
               next_col = CW'(col_inc);
            end
         end
         tcce_pkg::OpBell: begin
            next_dirty = dirty_ff | cur_bit;
            bell       = 1'b1;
         end
         tcce_pkg::OpBackspace: begin
            next_dirty = dirty_ff | cur_bit | (32'd1 << bs_row);
            next_row   = bs_row;
            next_col   = bs_col;
         end
         tcce_pkg::OpNewRow: begin
            next_dirty = dirty_ff | cur_bit;
            next_col   = '0;
            if (row_over) begin
               scroll = 1'b1;
            end else begin
               next_row = RW'(row_inc);
            end
         end
         tcce_pkg::OpOther: begin
            next_dirty = dirty_ff | cur_bit;
         end
         tcce_pkg::OpClear: begin
            next_row   = '0;
            next_col   = '0;
            next_dirty = dirty_ff | rows_mask;
         end
         tcce_pkg::OpRead, tcce_pkg::OpNop: begin
         end
         default: begin
         end
      endcase
      if (scroll) begin
         next_row   = RW'(rows - 1'b1);
         next_dirty = next_dirty | rows_mask;
      end
   end

   always_comb begin
      state_in        = state_ff;
      top_in          = top_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      dirty_in        = dirty_ff;
      init_in         = init_ff;
      sweep_addr_in   = sweep_addr_ff;
      sweep_last_in   = sweep_last_ff;
      item_in         = item_ff;
      rsp_valid_in    = 1'b0;
      rsp_row_in      = rsp_row_ff;
      rsp_col_in      = rsp_col_ff;
      rsp_char_in     = rsp_char_ff;
      rsp_bell_in     = rsp_bell_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      rsp_dirty_in    = rsp_dirty_ff;
      ram_we          = 1'b0;
      ram_waddr       = cell_addr;
      ram_wdata       = tcce_pkg::ChSpace;
      ram_raddr       = cell_addr;
      status.pop      = 1'b0;

      unique case (state_ff)
         S_SWEEP: begin
            ram_we    = 1'b1;
            ram_waddr = sweep_addr_ff;
            if (sweep_addr_ff == sweep_last_ff) begin
               state_in = S_IDLE;
               init_in  = 1'b0;
            end else begin
               sweep_addr_in = sweep_addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (head.valid) begin
               // row count may have shrunk: bring the top row back in range first
               if ({1'b0, top_ff} >= rows) begin
                  top_in = RW'({1'b0, top_ff} - rows);
               end else begin
                  status.pop = 1'b1;
                  item_in    = head.item;
                  state_in   = S_EXEC;
                  if ({1'b0, row_ff} >= rows) begin
                     row_in = RW'(rows - 1'b1);
                  end
                  if ({1'b0, col_ff} >= cols) begin
                     col_in = CW'(cols - 1'b1);
                  end
               end
            end
         end
         S_EXEC: begin
            state_in        = S_IDLE;
            row_in          = next_row;
            col_in          = next_col;
            rsp_row_in      = 5'(next_row);
            rsp_col_in      = 7'(next_col);
            rsp_char_in     = '0;
            rsp_bell_in     = bell;
            rsp_scrolled_in = scroll;
            rsp_dirty_in    = next_dirty;
            dirty_in        = item_ff.end_of_string ? '0 : next_dirty;
            rsp_valid_in    = 1'b1;
            if (item_ff.op == tcce_pkg::OpPrint) begin
               ram_we    = 1'b1;
               ram_wdata = item_ff.char_code;
            end
            if (item_ff.op == tcce_pkg::OpBackspace) begin
               ram_we = 1'b1;
            end
            if (scroll) begin
               top_in        = top_inc;
               sweep_addr_in = {top_ff, {CW{1'b0}}};
               sweep_last_in = {top_ff, LastCol};
               state_in      = S_SWEEP;
            end
            if (item_ff.op == tcce_pkg::OpClear) begin
               top_in        = '0;
               sweep_addr_in = '0;
               sweep_last_in = LastAddr;
               state_in      = S_SWEEP;
            end
            if (item_ff.op == tcce_pkg::OpRead && read_ok) begin
               rsp_valid_in = 1'b0;
               dirty_in     = dirty_ff;
               state_in     = S_READ;
            end
         end
         S_READ: begin
            state_in        = S_IDLE;
            rsp_valid_in    = 1'b1;
            rsp_row_in      = 5'(row_ff);
            rsp_col_in      = 7'(col_ff);
            rsp_char_in     = ram_rdata;
            rsp_bell_in     = 1'b0;
            rsp_scrolled_in = 1'b0;
            rsp_dirty_in    = dirty_ff;
            dirty_in        = item_ff.end_of_string ? '0 : dirty_ff;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign status.initialising = init_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         top_ff        <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         dirty_ff      <= tcce_pkg::DirtyReset;
         init_ff       <= 1'b1;
         sweep_addr_ff <= '0;
         sweep_last_ff <= LastAddr;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         top_ff        <= top_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         dirty_ff      <= dirty_in;
         init_ff       <= init_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_last_ff <= sweep_last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_ff         <= item_in;
      rsp_row_ff      <= rsp_row_in;
      rsp_col_ff      <= rsp_col_in;
      rsp_char_ff     <= rsp_char_in;
      rsp_bell_ff     <= rsp_bell_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
      rsp_dirty_ff    <= rsp_dirty_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_bell       = rsp_bell_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;
   assign rsp_dirty_rows = rsp_dirty_ff;

endmodule

`default_nettype wire

// ===== design/text_console_cursor_engine.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// Text console with cursor, scrolling, dirty-row tracking and cell reads.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a word is taken at a rising edge with start high and
//   busy low. req_kind selects put character, clear screen, read cell or no operation.
//   Result channel: exactly one word per command, shown for one cycle with
//   rsp_valid high; it cannot be held off by the receiver.
//   Register port: csr_write with csr_index writes column or row count at
//   once; write only while no command is outstanding.
// Sequence:
//   A command is popped from the queue in IDLE and carried out in EXEC,
//   which registers its result word; a cell read goes on through READ.
//   The back end pops only in IDLE, so it takes no new command before the
//   last has left EXEC or READ. A scroll adds a blanking sweep of one row,
//   a clear screen a sweep of the whole store; a row count reduction first
//   re-folds the top row. A two-word queue keeps start accepted meanwhile until full.
// Reset:
//   The whole store of MAX_ROWS * 2**clog2(MAX_COLUMNS) cells
//   (4096 by default) is swept to spaces, with busy high throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_engine #(
   parameter int MAX_COLUMNS = tcce_pkg::MaxColumnsDefault,
   parameter int MAX_ROWS    = tcce_pkg::MaxRowsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_end_of_string,
   input  wire logic [4:0]  req_read_row,
   input  wire logic [6:0]  req_read_col,
   output logic             rsp_valid,
   output logic [4:0]       rsp_cursor_row,
   output logic [6:0]       rsp_cursor_col,
   output logic [7:0]       rsp_cell_char,
   output logic             rsp_bell,
   output logic             rsp_scrolled,
   output logic [31:0]      rsp_dirty_rows,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);

   localparam int ColW = $clog2(MAX_COLUMNS) + 1;
   localparam int RowW = $clog2(MAX_ROWS) + 1;

   logic [7:0]                column_count_ff, column_count_in;
   logic [5:0]                row_count_ff, row_count_in;
   logic [ColW-1:0]           cols;
   logic [RowW-1:0]           rows;
   tcce_pkg::queue_head_type  head;
   tcce_pkg::back_status_type status;

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (csr_write) begin
         unique case (tcce_pkg::csr_index_type'(csr_index))
            tcce_pkg::CsrColumnCount: column_count_in = csr_wdata;
            tcce_pkg::CsrRowCount:    row_count_in    = csr_wdata[5:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= tcce_pkg::ColumnCountReset;
         row_count_ff    <= tcce_pkg::RowCountReset;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   // saturate geometry to 1..MAX
   always_comb begin
      priority if (column_count_ff == '0) begin
         cols = ColW'(1);
      end else if (9'(column_count_ff) > 9'(MAX_COLUMNS)) begin
         cols = ColW'(MAX_COLUMNS);
      end else begin
         cols = ColW'(column_count_ff);
      end
      priority if (row_count_ff == '0) begin
         rows = RowW'(1);
      end else if (7'(row_count_ff) > 7'(MAX_ROWS)) begin
         rows = RowW'(MAX_ROWS);
      end else begin
         rows = RowW'(row_count_ff);
      end
   end

   tcce_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .kind         (req_kind),
      .char_code    (req_char_code),
      .end_of_string(req_end_of_string),
      .read_row     (req_read_row),
      .read_col     (req_read_col),
      .status       (status),
      .head         (head)
   );

   tcce_back #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .MAX_ROWS   (MAX_ROWS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cols          (cols),
      .rows          (rows),
      .head          (head),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_cursor_row(rsp_cursor_row),
      .rsp_cursor_col(rsp_cursor_col),
      .rsp_cell_char (rsp_cell_char),
      .rsp_bell      (rsp_bell),
      .rsp_scrolled  (rsp_scrolled),
      .rsp_dirty_rows(rsp_dirty_rows)
   );

endmodule

`default_nettype wire

// ===== design/tcce_checker.sv =====
// ----------------------------------------------------------------------------
// tcce_checker
// Port-level checks of the text console cursor engine, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [6:0]  rsp_cursor_col,
   input wire logic [7:0]  rsp_cell_char,
   input wire logic        rsp_bell,
   input wire logic        rsp_scrolled,
   input wire logic [31:0] rsp_dirty_rows
);

   // store sweep holds commands off straight after reset
   a_busy_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("busy low right after reset");

   a_no_word_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");

   a_scroll_home: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled |-> rsp_cursor_col == 7'd0 && rsp_dirty_rows[0])
      else $error("scroll without column zero or full dirty mask");

   a_read_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cell_char != 8'd0 |-> !rsp_bell && !rsp_scrolled)
      else $error("cell read with bell or scroll");

   // every command passes through IDLE and EXEC, so result words never come back to back
   a_result_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("unexpected result timing");

endmodule

bind text_console_cursor_engine tcce_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_cursor_col(rsp_cursor_col),
   .rsp_cell_char (rsp_cell_char),
   .rsp_bell      (rsp_bell),
   .rsp_scrolled  (rsp_scrolled),
   .rsp_dirty_rows(rsp_dirty_rows)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console cursor engine. A behavioural
// screen model predicts cursor, cell, bell, scroll and dirty-row values for
// every command word; a monitor compares each result word against the
// oldest prediction. Directed control-code and geometry checks are followed
// by random traffic, bursty and steady, over several screen geometries.
// ----------------------------------------------------------------------------

module tb_top;

   localparam int MaxCols    = tcce_pkg::MaxColumnsDefault;
   localparam int MaxRows    = tcce_pkg::MaxRowsDefault;
   localparam int CycleLimit = 10_000_000;

   typedef struct packed {
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_col;
      logic [7:0]  cell_char;
      logic        bell;
      logic        scrolled;
      logic [31:0] dirty_rows;
   } console_word_type;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        start             = 1'b0;
   logic [1:0]  req_kind          = tcce_pkg::KindPut;
   logic [7:0]  req_char_code     = '0;
   logic        req_end_of_string = 1'b0;
   logic [4:0]  req_read_row      = '0;
   logic [6:0]  req_read_col      = '0;
   logic        csr_write         = 1'b0;
   logic        csr_index         = tcce_pkg::CsrColumnCount;
   logic [7:0]  csr_wdata         = '0;
   logic        busy;
   logic        rsp_valid;
   logic [4:0]  rsp_cursor_row;
   logic [6:0]  rsp_cursor_col;
   logic [7:0]  rsp_cell_char;
   logic        rsp_bell;
   logic        rsp_scrolled;
   logic [31:0] rsp_dirty_rows;

   // screen model
   logic [7:0]  screen_mem [MaxRows][MaxCols];
   int unsigned row_base;
   int unsigned cur_row;
   int unsigned cur_col;
   logic [31:0] dirty_mask;
   logic [7:0]  column_cfg;
   logic [5:0]  row_cfg;

   console_word_type expected_words[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned word_count     = 0;
   int unsigned geometry_count = 0;
   int unsigned scroll_count   = 0;
   int unsigned clear_count    = 0;
   int unsigned read_count     = 0;

   always #5 clock = ~clock;

   text_console_cursor_engine u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_char_code     (req_char_code),
      .req_end_of_string (req_end_of_string),
      .req_read_row      (req_read_row),
      .req_read_col      (req_read_col),
      .rsp_valid         (rsp_valid),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_col    (rsp_cursor_col),
      .rsp_cell_char     (rsp_cell_char),
      .rsp_bell          (rsp_bell),
      .rsp_scrolled      (rsp_scrolled),
      .rsp_dirty_rows    (rsp_dirty_rows),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   function automatic void blank_screen();
      for (int r = 0; r < MaxRows; r++) begin
         for (int c = 0; c < MaxCols; c++) begin
            screen_mem[r][c] = tcce_pkg::ChSpace;
         end
      end
   endfunction

   function automatic int unsigned cols_in_use();
      if (column_cfg == 0) return 1;
      if (column_cfg > MaxCols) return MaxCols;
      return column_cfg;
   endfunction

   function automatic int unsigned rows_in_use();
      if (row_cfg == 0) return 1;
      if (row_cfg > MaxRows) return MaxRows;
      return row_cfg;
   endfunction

   function automatic logic [31:0] row_mask(int unsigned rows);
      return (rows >= 32) ? '1 : ((32'd1 << rows) - 32'd1);
   endfunction

   // start of next row; scrolls when it runs off the bottom
   function automatic logic next_row(int unsigned rows);
      int unsigned bottom;
      cur_col = 0;
      cur_row++;
      if (cur_row < rows) return 1'b0;
      row_base = (row_base + 1) % rows;
      bottom   = (row_base + rows - 1) % rows;
      for (int c = 0; c < MaxCols; c++) begin
         screen_mem[bottom][c] = tcce_pkg::ChSpace;
      end
      cur_row = rows - 1;
      dirty_mask |= row_mask(rows);
      return 1'b1;
   endfunction

   function automatic console_word_type predict_console(
         tcce_pkg::kind_type kind, logic [7:0] ch,
         logic eos, logic [4:0] rr, logic [6:0] rc);
      int unsigned cols;
      int unsigned rows;
      console_word_type w;
      cols = cols_in_use();
      rows = rows_in_use();
      w    = '0;
      row_base = row_base % rows;
      if (cur_row >= rows) cur_row = rows - 1;
      if (cur_col >= cols) cur_col = cols - 1;
      case (kind)
         tcce_pkg::KindPut: begin
            dirty_mask[cur_row] = 1'b1;
            if (ch >= tcce_pkg::ChSpace && ch <= tcce_pkg::ChTilde) begin
               screen_mem[(row_base + cur_row) % rows][cur_col] = ch;
               cur_col++;
               if (cur_col >= cols) w.scrolled = next_row(rows);
            end else if (ch == tcce_pkg::ChBel) begin
               w.bell = 1'b1;
            end else if (ch == tcce_pkg::ChBs) begin
               if (cur_col > 0) cur_col--;
               else if (cur_row > 0) cur_row--;
               screen_mem[(row_base + cur_row) % rows][cur_col] = tcce_pkg::ChSpace;
               dirty_mask[cur_row] = 1'b1;
            end else if (ch == tcce_pkg::ChLf || ch == tcce_pkg::ChCr) begin
               w.scrolled = next_row(rows);
            end
         end
         tcce_pkg::KindClear: begin
            blank_screen();
            row_base = 0;
            cur_row  = 0;
            cur_col  = 0;
            dirty_mask |= row_mask(rows);
         end
         tcce_pkg::KindRead: begin
            if (rr < rows && rc < cols) w.cell_char = screen_mem[(row_base + rr) % rows][rc];
         end
         default: ;
      endcase
      w.cursor_row = cur_row[4:0];
      w.cursor_col = cur_col[6:0];
      w.dirty_rows = dirty_mask;
      if (eos) dirty_mask = '0;
      return w;
   endfunction

   task automatic send_word(tcce_pkg::kind_type kind, logic [7:0] ch, logic eos,
         logic [4:0] rr = '0, logic [6:0] rc = '0);
      console_word_type w;
      start             <= 1'b1;
      req_kind          <= kind;
      req_char_code     <= ch;
      req_end_of_string <= eos;
      req_read_row      <= rr;
      req_read_col      <= rc;
      do @(posedge clock); while (busy !== 1'b0);
      w = predict_console(kind, ch, eos, rr, rc);
      expected_words.push_back(w);
      word_count++;
      if (w.scrolled) scroll_count++;
      if (kind == tcce_pkg::KindClear) clear_count++;
      if (kind == tcce_pkg::KindRead) read_count++;
   endtask

   // sender stops until every result word is back and the engine has settled
   task automatic wait_idle();
      start <= 1'b0;
      while (expected_words.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (8) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic write_geometry(logic [7:0] cols, logic [7:0] rows);
      csr_write <= 1'b1;
      csr_index <= tcce_pkg::CsrColumnCount;
      csr_wdata <= cols;
      @(posedge clock);
      column_cfg = cols;
      csr_index <= tcce_pkg::CsrRowCount;
      csr_wdata <= rows;
      @(posedge clock);
      row_cfg = rows[5:0];
      csr_write <= 1'b0;
      geometry_count++;
   endtask

   task automatic send_random_item();
      int unsigned        pick;
      tcce_pkg::kind_type kind;
      logic [7:0]         ch;
      logic               eos;
      logic [4:0]         rr;
      logic [6:0]         rc;
      pick = $urandom_range(0, 999);
      kind = tcce_pkg::KindPut;
      eos  = ($urandom_range(0, 3) == 0);
      rr   = 5'($urandom);
      rc   = 7'($urandom);
      ch   = 8'($urandom_range(tcce_pkg::ChSpace, tcce_pkg::ChTilde));
      if (pick < 80) begin
         ch = ($urandom_range(0, 1) == 0) ? tcce_pkg::ChLf : tcce_pkg::ChCr;
      end else if (pick < 140) begin
         ch = tcce_pkg::ChBs;
      end else if (pick < 170) begin
         ch = tcce_pkg::ChBel;
      end else if (pick < 230) begin
         ch = 8'($urandom);
      end else if (pick < 350) begin
         kind = tcce_pkg::KindRead;
         if (pick < 320) begin
            rr = 5'($urandom_range(0, rows_in_use() - 1));
            rc = 7'($urandom_range(0, cols_in_use() - 1));
         end
      end else if (pick < 358) begin
         kind = tcce_pkg::KindClear;
      end else if (pick < 370) begin
         kind = tcce_pkg::KindNone;
      end
      send_word(kind, ch, eos, rr, rc);
   endtask

   task automatic send_stream(int unsigned count, bit steady);
      int unsigned left;
      int unsigned burst;
      left = count;
      while (left > 0) begin
         burst = steady ? left : $urandom_range(1, 12);
         if (burst > left) burst = left;
         repeat (burst) send_random_item();
         left -= burst;
         if (!steady && left > 0 && $urandom_range(0, 2) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
      end
   endtask

   task automatic test_control_codes();
      logic [7:0] odd_bytes [5];
      odd_bytes = '{8'h1F, 8'h7F, 8'h80, 8'hFF, 8'h00};
      send_word(tcce_pkg::KindRead, 8'h00, 1'b0, 5'd0, 7'd0);
      send_word(tcce_pkg::KindPut, tcce_pkg::ChSpace, 1'b0);
      send_word(tcce_pkg::KindPut, tcce_pkg::ChTilde, 1'b0);
      foreach (odd_bytes[i]) send_word(tcce_pkg::KindPut, odd_bytes[i], 1'b0);
      send_word(tcce_pkg::KindPut, tcce_pkg::ChBel, 1'b0);
      send_word(tcce_pkg::KindPut, tcce_pkg::ChBs, 1'b0);
      send_word(tcce_pkg::KindPut, tcce_pkg::ChCr, 1'b0);
      send_word(tcce_pkg::KindPut, tcce_pkg::ChBs, 1'b0);   // column zero: back up a row
      send_word(tcce_pkg::KindPut, tcce_pkg::ChBs, 1'b1);   // already at top-left
      send_word(tcce_pkg::KindPut, tcce_pkg::ChLf, 1'b0);
      send_word(tcce_pkg::KindRead, 8'hFF, 1'b0, 5'd0, 7'd1);
      send_word(tcce_pkg::KindRead, 8'h00, 1'b1, 5'd31, 7'd127);
      send_word(tcce_pkg::KindNone, 8'hFF, 1'b0, 5'd31, 7'd127);
      send_word(tcce_pkg::KindClear, 8'h00, 1'b1);
   endtask

   task automatic test_geometry_extremes();
      wait_idle();
      write_geometry(8'd0, 8'd0);       // saturates to one cell
      send_word(tcce_pkg::KindPut, 8'h78, 1'b0);
      send_word(tcce_pkg::KindPut, tcce_pkg::ChLf, 1'b0);
      send_word(tcce_pkg::KindRead, 8'h00, 1'b0, 5'd0, 7'd0);
      send_word(tcce_pkg::KindRead, 8'h00, 1'b1, 5'd1, 7'd0);
      wait_idle();
      write_geometry(8'hFF, 8'h3F);     // saturates to the full store
      send_word(tcce_pkg::KindPut, 8'h41, 1'b0);
      send_word(tcce_pkg::KindRead, 8'h00, 1'b0, 5'd31, 7'd127);
      send_word(tcce_pkg::KindRead, 8'h00, 1'b1, 5'd0, 7'd0);
   endtask

   task automatic test_random_traffic();
      logic [7:0] cols;
      logic [7:0] rows;
      for (int phase = 0; phase < 8; phase++) begin
         wait_idle();
         case (phase)
            0: begin cols = 8'd255; rows = 8'hFF; end
            1: begin cols = 8'd0;   rows = 8'hC0; end
            2: begin cols = 8'd128; rows = 8'd32; end
            3: begin
               cols = tcce_pkg::ColumnCountReset;
               rows = {2'b00, tcce_pkg::RowCountReset};
            end
            default: begin
               cols = 8'($urandom_range(1, 16));
               rows = {2'($urandom), 6'($urandom_range(1, 8))};
            end
         endcase
         write_geometry(cols, rows);
         send_stream(50, (phase % 3) == 1);
      end
   endtask

   task automatic report_mismatch(string what, console_word_type exp_w,
         console_word_type got_w);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t %s: expected row %0d col %0d char %h bell %b scroll %b dirty %h",
                  $realtime, what, exp_w.cursor_row, exp_w.cursor_col, exp_w.cell_char,
                  exp_w.bell, exp_w.scrolled, exp_w.dirty_rows);
         $display("      got row %0d col %0d char %h bell %b scroll %b dirty %h",
                  got_w.cursor_row, got_w.cursor_col, got_w.cell_char,
                  got_w.bell, got_w.scrolled, got_w.dirty_rows);
      end
   endtask

   always @(posedge clock) begin
      console_word_type got_w;
      console_word_type exp_w;
      if (!reset && rsp_valid === 1'b1) begin
         got_w = {rsp_cursor_row, rsp_cursor_col, rsp_cell_char,
                  rsp_bell, rsp_scrolled, rsp_dirty_rows};
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", '0, got_w);
         end else begin
            exp_w = expected_words.pop_front();
            if (got_w !== exp_w) report_mismatch("word mismatch", exp_w, got_w);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Run stopped at cycle limit, %0d words outstanding",
                  expected_words.size());
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      blank_screen();
      row_base   = 0;
      cur_row    = 0;
      cur_col    = 0;
      dirty_mask = tcce_pkg::DirtyReset;
      column_cfg = tcce_pkg::ColumnCountReset;
      row_cfg    = tcce_pkg::RowCountReset;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait_idle();
      test_control_codes();
      test_geometry_extremes();
      test_random_traffic();
      wait_idle();
      repeat (20) @(posedge clock);
      $display("Checked %0d command words across %0d screen geometries", word_count,
               geometry_count);
      $display("Run saw %0d scrolls, %0d screen clears and %0d cell reads", scroll_count,
               clear_count, read_count);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/tcce_pkg.sv
design/tcce_ram.sv
design/tcce_front.sv
design/tcce_back.sv
design/text_console_cursor_engine.sv
design/tcce_checker.sv
verif/tb_top.sv
